FILE: rtl/utf8v_pkg.sv
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types, byte ranges and helpers for the UTF-8 text validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  // configuration register indexes
  typedef enum logic {
    CFG_MAX_LENGTH  = 1'b0,
    CFG_ALLOW_EMPTY = 1'b1
  } cfg_idx_t;

  // sequence class of the current multi-byte sequence (smallest legal value)
  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_TWO   = 2'd1,
    CLS_THREE = 2'd2,
    CLS_FOUR  = 2'd3
  } seq_class_t;

  localparam int unsigned CountWidth = 17;
  localparam int unsigned CpWidth    = 21;

  // lead byte ranges
  localparam logic [7:0] CtrlLast   = 8'h1f;
  localparam logic [7:0] AsciiDel   = 8'h7f;
  localparam logic [7:0] Lead2Lo    = 8'hc2;
  localparam logic [7:0] Lead2Hi    = 8'hdf;
  localparam logic [7:0] Lead3Lo    = 8'he0;
  localparam logic [7:0] Lead3Hi    = 8'hef;
  localparam logic [7:0] Lead4Lo    = 8'hf0;
  localparam logic [7:0] Lead4Hi    = 8'hf4;

  // code point limits
  localparam logic [CpWidth-1:0] CpMin2   = 21'h000080;
  localparam logic [CpWidth-1:0] CpMin3   = 21'h000800;
  localparam logic [CpWidth-1:0] CpMin4   = 21'h010000;
  localparam logic [CpWidth-1:0] CpMax    = 21'h10ffff;
  localparam logic [CpWidth-1:0] SurrLo   = 21'h00d800;
  localparam logic [CpWidth-1:0] SurrHi   = 21'h00dfff;

  // smallest code point a sequence of the given class may encode
  function automatic logic [CpWidth-1:0] min_value(input seq_class_t cls);
    logic [CpWidth-1:0] v;
    unique case (cls)
      CLS_TWO:   v = CpMin2;
      CLS_THREE: v = CpMin3;
      default:   v = CpMin4;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/utf8_text_validator_top.sv
// ----------------------------------------------------------------------------
// utf8_text_validator_top
// Checks strings of bytes as printable, length-bounded UTF-8 text and gives
// one verdict word per string on its closing word.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | tdata: text_byte, tuser: empty_marker, tlast: last_byte
//  m_axis    | out       | tdata: text_ok (bit 0)
//  cfg       | in        | index 0 max_length, index 1 allow_empty
//
//  One word per cycle while no verdict is stalled: the decoder state
//  registers take each word in the cycle it is accepted, and the verdict
//  lands in the output register, valid in the cycle after its closing word.
//  A verdict stalled in the output register holds off every input word until
//  it is taken (tready = !tvalid out | tready out).
//  Reset (rst, synchronous) clears decoder state and the output valid, and
//  sets max_length to 255 and allow_empty to 0. cfg_ready is always high.
// ----------------------------------------------------------------------------
module utf8_text_validator_top (
  input  logic                clk,
  input  logic                rst,
  // input words
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] text_byte
  input  logic                s_axis_tuser,   // [0] empty_marker
  input  logic                s_axis_tlast,   // last_byte
  // verdict words
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [0] text_ok, [7:1] zero
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  utf8v_pkg::cfg_idx_t cfg_index,
  input  logic [15:0]         cfg_data
);
  import utf8v_pkg::*;

  // configuration registers
  logic [15:0] max_length;
  logic        allow_empty;

  // decoder state
  logic [1:0]            bytes_left;
  logic [CpWidth-1:0]    code_point;
  seq_class_t            min_class;
  logic                  failed;
  logic [CountWidth-1:0] byte_count;

  logic [1:0]            bytes_left_next;
  logic [CpWidth-1:0]    code_point_next;
  seq_class_t            min_class_next;
  logic                  failed_next;
  logic [CountWidth-1:0] byte_count_next;
  logic                  verdict;

  // output register
  logic out_valid;
  logic text_ok;

  logic in_acc;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, text_ok};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length  <= 16'd255;
      allow_empty <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_LENGTH:  max_length  <= cfg_data;
        CFG_ALLOW_EMPTY: allow_empty <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // byte decode and verdict
  always_comb begin
    bytes_left_next = bytes_left;
    code_point_next = code_point;
    min_class_next  = min_class;
    failed_next     = failed;
    byte_count_next = byte_count;
    if (!s_axis_tuser) begin
      // count saturates one past the bound
      if (byte_count <= {1'b0, max_length}) begin
        byte_count_next = byte_count + CountWidth'(1);
      end
      if (!failed) begin
        if (bytes_left == 2'd0) begin
          case (s_axis_tdata) inside
            [8'h00:CtrlLast], AsciiDel: failed_next = 1'b1;
            [8'h20:8'h7e]: ;
            [Lead2Lo:Lead2Hi]: begin
              bytes_left_next = 2'd1;
              min_class_next  = CLS_TWO;
              code_point_next = {16'd0, s_axis_tdata[4:0]};
            end
            [Lead3Lo:Lead3Hi]: begin
              bytes_left_next = 2'd2;
              min_class_next  = CLS_THREE;
              code_point_next = {17'd0, s_axis_tdata[3:0]};
            end
            [Lead4Lo:Lead4Hi]: begin
              bytes_left_next = 2'd3;
              min_class_next  = CLS_FOUR;
              code_point_next = {18'd0, s_axis_tdata[2:0]};
            end
            default: failed_next = 1'b1;
          endcase
        end else if (s_axis_tdata[7:6] != 2'b10) begin
          failed_next = 1'b1;
        end else begin
          code_point_next = {code_point[CpWidth-7:0], s_axis_tdata[5:0]};
          bytes_left_next = bytes_left - 2'd1;
          // overlong, out of range or surrogate once the sequence completes
          if (bytes_left_next == 2'd0 &&
              (code_point_next < min_value(min_class) || code_point_next > CpMax ||
               (code_point_next >= SurrLo && code_point_next <= SurrHi))) begin
            failed_next = 1'b1;
          end
        end
        if (failed_next) bytes_left_next = 2'd0;
      end
    end
    verdict = !failed_next && (bytes_left_next == 2'd0) &&
              (byte_count_next <= {1'b0, max_length}) &&
              ((byte_count_next != '0) || allow_empty);
  end

  // decoder state, cleared after each verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= 2'd0;
      code_point <= '0;
      min_class  <= CLS_NONE;
      failed     <= 1'b0;
      byte_count <= '0;
    end else if (in_acc) begin
      if (s_axis_tlast) begin
        bytes_left <= 2'd0;
        code_point <= '0;
        min_class  <= CLS_NONE;
        failed     <= 1'b0;
        byte_count <= '0;
      end else begin
        bytes_left <= bytes_left_next;
        code_point <= code_point_next;
        min_class  <= min_class_next;
        failed     <= failed_next;
        byte_count <= byte_count_next;
      end
    end
  end

  // verdict output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && s_axis_tlast) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && s_axis_tlast) text_ok <= verdict;
  end

  // checks
  a_left_within_class: assert property (@(posedge clk) disable iff (rst)
    bytes_left <= min_class)
    else $error("bytes_left exceeds the sequence class");

  a_fail_ends_seq: assert property (@(posedge clk) disable iff (rst)
    failed |-> bytes_left == 2'd0)
    else $error("sequence still open after failure");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_axis_tlast |=> m_axis_tvalid && byte_count == '0 && !failed)
    else $error("closing word did not give a verdict and clear state");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

endmodule
